// ----- rtl/bnfa_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the boid neighbor force accumulator.
// No dependencies; the ctrl, dp, div and top files import this package.
package bnfa_pkg;

	localparam int unsigned MaxNeighborsDef = 256;
	localparam int unsigned CntW  = 9;
	localparam int unsigned RadW  = 12;
	localparam int unsigned SumW  = 24;
	localparam int unsigned SepW  = 40;
	localparam int unsigned DivNW = 40;
	localparam int unsigned DivDW = 32;
	localparam int unsigned AddrW = 4;

	localparam logic [RadW-1:0] AlignRadiusRst = 12'd100;
	localparam logic [RadW-1:0] SepRadiusRst   = 12'd500;
	localparam logic [RadW-1:0] CohRadiusRst   = 12'd100;

	typedef enum logic [1:0] {
		REG_ALIGN_RADIUS = 2'd0,
		REG_SEP_RADIUS   = 2'd1,
		REG_COH_RADIUS   = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_CALC,
		ST_APPLY,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_SEP_ADD,
		ST_LAST,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		MS_DX = 3'd0,
		MS_DY = 3'd1,
		MS_AR = 3'd2,
		MS_SR = 3'd3,
		MS_CR = 3'd4,
		MS_DD = 3'd5
	} mul_sel_t;

	typedef enum logic [2:0] {
		DS_PX = 3'd0,
		DS_PY = 3'd1,
		DS_AX = 3'd2,
		DS_AY = 3'd3,
		DS_SX = 3'd4,
		DS_SY = 3'd5,
		DS_CX = 3'd6,
		DS_CY = 3'd7
	} div_sel_t;

	typedef struct packed {
		logic     capture;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     calc;
		logic     apply;
		logic     div_start;
		div_sel_t div_sel;
		logic     div_store;
		logic     sep_add;
		logic     load_out;
		logic     clear;
	} cmd_t;

	typedef struct packed {
		logic            div_done;
		logic            sep_div;
		logic            last;
		logic            out_busy;
		logic [CntW-1:0] align_cnt;
		logic [CntW-1:0] sep_cnt;
		logic [CntW-1:0] coh_cnt;
	} status_t;

endpackage

// ----- rtl/bnfa_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channels: neighbor items in, averaged force items out.
// Depends on nothing.
interface bnfa_nbr_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] delta_x;
	logic signed [15:0] delta_y;
	logic signed [15:0] neighbor_vel_x;
	logic signed [15:0] neighbor_vel_y;
	logic [11:0]        desired_distance;
	logic               is_self;
	logic               last;

	modport source (output valid, delta_x, delta_y, neighbor_vel_x, neighbor_vel_y,
		desired_distance, is_self, last, input ready);
	modport sink (input valid, delta_x, delta_y, neighbor_vel_x, neighbor_vel_y,
		desired_distance, is_self, last, output ready);
endinterface

interface bnfa_force_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] alignment_x;
	logic signed [15:0] alignment_y;
	logic signed [29:0] separation_x;
	logic signed [29:0] separation_y;
	logic signed [15:0] cohesion_x;
	logic signed [15:0] cohesion_y;
	logic [8:0]         alignment_count;
	logic [8:0]         separation_count;
	logic [8:0]         cohesion_count;

	modport source (output valid, alignment_x, alignment_y, separation_x, separation_y,
		cohesion_x, cohesion_y, alignment_count, separation_count, cohesion_count,
		input ready);
	modport sink (input valid, alignment_x, alignment_y, separation_x, separation_y,
		cohesion_x, cohesion_y, alignment_count, separation_count, cohesion_count,
		output ready);
endinterface

// ----- rtl/bnfa_div.sv -----
`timescale 1ns / 1ps
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on bnfa_pkg.
module bnfa_div import bnfa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DivNW-1:0] num,
	input  logic [DivDW-1:0] den,
	output logic             done,
	output logic [DivNW-1:0] quo
);
	localparam int unsigned CW = $clog2(DivNW);

	logic [DivNW-1:0] quo_q;
	logic [DivDW-1:0] rem_q;
	logic [DivDW-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DivDW:0]   trial;
	logic             ge;

	// numerator shifts out of the top of quo_q while quotient bits shift in
	assign trial = {rem_q, quo_q[DivNW-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DivNW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? DivDW'(trial - {1'b0, den_q}) : trial[DivDW-1:0];
			quo_q <= {quo_q[DivNW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

// ----- rtl/bnfa_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer: steps the datapath through squares, compares, divisions and averaging.
// Depends on bnfa_pkg.
module bnfa_ctrl import bnfa_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t st,
	output cmd_t    cmd
);
	state_t   state_q, state_d;
	mul_sel_t mul_q;
	div_sel_t dsel_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_MUL;
			ST_MUL:      if (mul_q == MS_DD) state_d = ST_CALC;
			ST_CALC:     state_d = ST_APPLY;
			ST_APPLY:    state_d = st.sep_div ? ST_DIV_GO : ST_LAST;
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (st.div_done) begin
					if (dsel_q == DS_PY) state_d = ST_SEP_ADD;
					else if (dsel_q == DS_CY) state_d = ST_OUT;
					else state_d = ST_DIV_GO;
				end
			end
			ST_SEP_ADD:  state_d = ST_LAST;
			ST_LAST:     state_d = st.last ? ST_DIV_GO : ST_IDLE;
			ST_OUT:      if (!st.out_busy) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.mul_sel   = mul_q;
		cmd.div_sel   = dsel_q;
		in_ready      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_MUL:      cmd.mul_en    = 1'b1;
			ST_CALC:     cmd.calc      = 1'b1;
			ST_APPLY:    cmd.apply     = 1'b1;
			ST_DIV_GO:   cmd.div_start = 1'b1;
			ST_DIV_WAIT: cmd.div_store = st.div_done;
			ST_SEP_ADD:  cmd.sep_add   = 1'b1;
			ST_OUT: begin
				cmd.load_out = !st.out_busy;
				cmd.clear    = !st.out_busy;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mul_q   <= MS_DX;
			dsel_q  <= DS_PX;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) mul_q <= MS_DX;
			else if (state_q == ST_MUL && mul_q != MS_DD) mul_q <= mul_sel_t'(mul_q + 3'd1);
			if (state_q == ST_APPLY) dsel_q <= DS_PX;
			else if (state_q == ST_LAST) dsel_q <= DS_AX;
			else if (state_q == ST_DIV_WAIT && st.div_done) dsel_q <= div_sel_t'(dsel_q + 3'd1);
		end
	end
endmodule

// ----- rtl/bnfa_dp.sv -----
`timescale 1ns / 1ps
// Datapath: config registers, shared multiplier, sums and counts, divider, output register.
// Depends on bnfa_pkg and bnfa_div.
module bnfa_dp import bnfa_pkg::*; #(
	parameter int unsigned MAX_NEIGHBORS = MaxNeighborsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output status_t            st,
	input  logic signed [15:0] delta_x,
	input  logic signed [15:0] delta_y,
	input  logic signed [15:0] neighbor_vel_x,
	input  logic signed [15:0] neighbor_vel_y,
	input  logic [RadW-1:0]    desired_distance,
	input  logic               is_self,
	input  logic               last,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [AddrW-1:0]   paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] alignment_x,
	output logic signed [15:0] alignment_y,
	output logic signed [29:0] separation_x,
	output logic signed [29:0] separation_y,
	output logic signed [15:0] cohesion_x,
	output logic signed [15:0] cohesion_y,
	output logic [CntW-1:0]    alignment_count,
	output logic [CntW-1:0]    separation_count,
	output logic [CntW-1:0]    cohesion_count
);
	localparam int unsigned CapInt = (MAX_NEIGHBORS < 511) ? MAX_NEIGHBORS : 511;
	localparam logic [CntW-1:0] CountCap = CntW'(CapInt);

	function automatic logic [15:0] mag16(input logic signed [15:0] v);
		mag16 = v[15] ? 16'(-v) : 16'(v);
	endfunction

	function automatic logic [39:0] mag40(input logic signed [39:0] v);
		mag40 = v[39] ? 40'(-v) : 40'(v);
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
		if (v[24] != v[23]) sat24 = v[24] ? 24'sh800000 : 24'sh7FFFFF;
		else sat24 = v[23:0];
	endfunction

	function automatic logic signed [39:0] sat40(input logic signed [41:0] v);
		if (v > 42'sh007FFFFFFFFF) sat40 = {1'b0, {39{1'b1}}};
		else if (v < -42'sh008000000000) sat40 = {1'b1, 39'd0};
		else sat40 = v[39:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [40:0] v);
		if (v > 41'sd32767) sat16 = 16'sh7FFF;
		else if (v < -41'sd32768) sat16 = 16'sh8000;
		else sat16 = v[15:0];
	endfunction

	function automatic logic signed [29:0] sat30(input logic signed [40:0] v);
		if (v > 41'sd536870911) sat30 = {1'b0, {29{1'b1}}};
		else if (v < -41'sd536870912) sat30 = {1'b1, 29'd0};
		else sat30 = v[29:0];
	endfunction

	// configuration
	logic [RadW-1:0] ar_q, sr_q, cr_q;
	logic            cfg_wr;
	reg_idx_t        cfg_idx;

	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ar_q <= AlignRadiusRst;
			sr_q <= SepRadiusRst;
			cr_q <= CohRadiusRst;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_ALIGN_RADIUS: ar_q <= pwdata[RadW-1:0];
				REG_SEP_RADIUS:   sr_q <= pwdata[RadW-1:0];
				REG_COH_RADIUS:   cr_q <= pwdata[RadW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_ALIGN_RADIUS: prdata = {20'd0, ar_q};
			REG_SEP_RADIUS:   prdata = {20'd0, sr_q};
			REG_COH_RADIUS:   prdata = {20'd0, cr_q};
			default:          prdata = '0;
		endcase
	end

	// captured item
	logic signed [15:0] dx_q, dy_q, vx_q, vy_q;
	logic [RadW-1:0]    dd_q;
	logic               self_q, last_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			dx_q   <= delta_x;
			dy_q   <= delta_y;
			vx_q   <= neighbor_vel_x;
			vy_q   <= neighbor_vel_y;
			dd_q   <= desired_distance;
			self_q <= is_self;
			last_q <= last;
		end
	end

	// one shared multiplier, one product per cycle
	logic [15:0] mul_a;
	logic [31:0] prod;
	logic [31:0] sqx_q, sqy_q;
	logic [23:0] ar2_q, sr2_q, cr2_q, dd2_q;

	always_comb begin
		case (cmd.mul_sel)
			MS_DX:   mul_a = mag16(dx_q);
			MS_DY:   mul_a = mag16(dy_q);
			MS_AR:   mul_a = {4'd0, ar_q};
			MS_SR:   mul_a = {4'd0, sr_q};
			MS_CR:   mul_a = {4'd0, cr_q};
			MS_DD:   mul_a = {4'd0, dd_q};
			default: mul_a = '0;
		endcase
	end
	assign prod = mul_a * mul_a;

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			case (cmd.mul_sel)
				MS_DX:   sqx_q <= prod;
				MS_DY:   sqy_q <= prod;
				MS_AR:   ar2_q <= prod[23:0];
				MS_SR:   sr2_q <= prod[23:0];
				MS_CR:   cr2_q <= prod[23:0];
				MS_DD:   dd2_q <= prod[23:0];
				default: ;
			endcase
		end
	end

	// range tests
	logic [32:0]     d2;
	logic [DivDW-1:0] d2_q;
	logic            al_hit_q, sep_hit_q, coh_hit_q, d2z_q;
	logic [CntW-1:0] acnt_q, scnt_q, ccnt_q;

	assign d2 = {1'b0, sqx_q} + {1'b0, sqy_q};

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			d2_q      <= d2[DivDW-1:0];
			d2z_q     <= (d2 == '0);
			al_hit_q  <= !self_q && (d2 < {1'b0, ar2_q, 8'd0}) && (acnt_q < CountCap);
			coh_hit_q <= !self_q && (d2 < {1'b0, cr2_q, 8'd0}) && (ccnt_q < CountCap);
			sep_hit_q <= !self_q && (d2 < {1'b0, sr2_q, 8'd0}) && (d2 < {1'b0, dd2_q, 8'd0})
				&& (scnt_q < CountCap);
		end
	end

	// divider and its operand select
	logic [DivNW-1:0] div_num, quo;
	logic [DivDW-1:0] div_den;
	logic             div_neg, div_done;
	logic signed [40:0] div_res;
	logic signed [SumW-1:0] ax_q, ay_q, cx_q, cy_q;
	logic signed [SepW-1:0] sx_q, sy_q;
	logic [DivDW-1:0] aden, sden, cden;

	assign aden = (acnt_q == '0) ? DivDW'(1) : DivDW'(acnt_q);
	assign sden = (scnt_q == '0) ? DivDW'(1) : DivDW'(scnt_q);
	assign cden = (ccnt_q == '0) ? DivDW'(1) : DivDW'(ccnt_q);

	always_comb begin
		case (cmd.div_sel)
			DS_PX: begin
				div_num = {4'd0, mag16(dx_q), 20'd0}; div_den = d2_q; div_neg = dx_q[15];
			end
			DS_PY: begin
				div_num = {4'd0, mag16(dy_q), 20'd0}; div_den = d2_q; div_neg = dy_q[15];
			end
			DS_AX: begin
				div_num = mag40(SepW'(ax_q)); div_den = aden; div_neg = ax_q[SumW-1];
			end
			DS_AY: begin
				div_num = mag40(SepW'(ay_q)); div_den = aden; div_neg = ay_q[SumW-1];
			end
			DS_SX: begin
				div_num = mag40(sx_q); div_den = sden; div_neg = sx_q[SepW-1];
			end
			DS_SY: begin
				div_num = mag40(sy_q); div_den = sden; div_neg = sy_q[SepW-1];
			end
			DS_CX: begin
				div_num = mag40(SepW'(cx_q)); div_den = cden; div_neg = cx_q[SumW-1];
			end
			DS_CY: begin
				div_num = mag40(SepW'(cy_q)); div_den = cden; div_neg = cy_q[SumW-1];
			end
			default: begin
				div_num = '0; div_den = DivDW'(1); div_neg = 1'b0;
			end
		endcase
	end

	bnfa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (quo)
	);

	assign div_res = div_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

	logic signed [40:0] px_q, py_q;
	logic signed [15:0] avg_ax_q, avg_ay_q, avg_cx_q, avg_cy_q;
	logic signed [29:0] avg_sx_q, avg_sy_q;

	always_ff @(posedge clk) begin
		if (cmd.div_store) begin
			case (cmd.div_sel)
				DS_PX:   px_q     <= div_res;
				DS_PY:   py_q     <= div_res;
				DS_AX:   avg_ax_q <= sat16(div_res);
				DS_AY:   avg_ay_q <= sat16(div_res);
				DS_SX:   avg_sx_q <= sat30(div_res);
				DS_SY:   avg_sy_q <= sat30(div_res);
				DS_CX:   avg_cx_q <= sat16(div_res);
				DS_CY:   avg_cy_q <= sat16(div_res);
				default: ;
			endcase
		end
	end

	// running sums and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q <= '0; ay_q <= '0; cx_q <= '0; cy_q <= '0;
			sx_q <= '0; sy_q <= '0;
			acnt_q <= '0; scnt_q <= '0; ccnt_q <= '0;
		end else if (cmd.clear) begin
			ax_q <= '0; ay_q <= '0; cx_q <= '0; cy_q <= '0;
			sx_q <= '0; sy_q <= '0;
			acnt_q <= '0; scnt_q <= '0; ccnt_q <= '0;
		end else if (cmd.apply) begin
			if (al_hit_q) begin
				ax_q   <= sat24({ax_q[SumW-1], ax_q} + 25'(vx_q));
				ay_q   <= sat24({ay_q[SumW-1], ay_q} + 25'(vy_q));
				acnt_q <= acnt_q + 1'b1;
			end
			if (coh_hit_q) begin
				cx_q   <= sat24({cx_q[SumW-1], cx_q} + 25'(dx_q));
				cy_q   <= sat24({cy_q[SumW-1], cy_q} + 25'(dy_q));
				ccnt_q <= ccnt_q + 1'b1;
			end
			// coincident neighbor: push along x by the desired distance
			if (sep_hit_q && d2z_q) begin
				sx_q   <= sat40(42'(sx_q) - $signed({14'd0, dd_q, 16'd0}));
				scnt_q <= scnt_q + 1'b1;
			end
		end else if (cmd.sep_add) begin
			sx_q   <= sat40(42'(sx_q) - 42'(px_q));
			sy_q   <= sat40(42'(sy_q) - 42'(py_q));
			scnt_q <= scnt_q + 1'b1;
		end
	end

	// output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.load_out) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			alignment_x      <= avg_ax_q;
			alignment_y      <= avg_ay_q;
			separation_x     <= avg_sx_q;
			separation_y     <= avg_sy_q;
			cohesion_x       <= avg_cx_q;
			cohesion_y       <= avg_cy_q;
			alignment_count  <= acnt_q;
			separation_count <= scnt_q;
			cohesion_count   <= ccnt_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign st.div_done  = div_done;
	assign st.sep_div   = sep_hit_q && !d2z_q;
	assign st.last      = last_q;
	assign st.out_busy  = out_valid_q && !out_ready;
	assign st.align_cnt = acnt_q;
	assign st.sep_cnt   = scnt_q;
	assign st.coh_cnt   = ccnt_q;
endmodule

// ----- rtl/boid_neighbor_force_accumulator.sv -----
`timescale 1ns / 1ps
// Top level of the boid neighbor force accumulator: sequencer plus datapath.
// Depends on bnfa_pkg, bnfa_if, bnfa_ctrl, bnfa_dp, bnfa_div.
//
//  port     dir   kind        content
//  nbr      in    valid/ready one neighbor item
//  forces   out   valid/ready averaged forces and counts, on last items
//  p*       in    APB         radius registers at 0x0, 0x4, 0x8
//
// An item without a separation push makes six passes through the shared
// 16x16 multiplier. A separation push adds two divisions on the 40-step
// divider, plus the add state. A last item adds six averaging divisions,
// then waits until the output register is free.
// Reset is asynchronous and clears sums, counts and control; radii reload.
// The next item is accepted while a result waits in the output register.
module boid_neighbor_force_accumulator import bnfa_pkg::*; #(
	parameter int unsigned MAX_NEIGHBORS = MaxNeighborsDef
) (
	input  logic             clk,
	input  logic             arst_n,
	bnfa_nbr_if.sink         nbr,
	bnfa_force_if.source     forces,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	cmd_t    cmd;
	status_t st;
	logic    in_ready;

	assign nbr.ready = in_ready;

	bnfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (nbr.valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	bnfa_dp #(.MAX_NEIGHBORS(MAX_NEIGHBORS)) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.st               (st),
		.delta_x          (nbr.delta_x),
		.delta_y          (nbr.delta_y),
		.neighbor_vel_x   (nbr.neighbor_vel_x),
		.neighbor_vel_y   (nbr.neighbor_vel_y),
		.desired_distance (nbr.desired_distance),
		.is_self          (nbr.is_self),
		.last             (nbr.last),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.out_valid        (forces.valid),
		.out_ready        (forces.ready),
		.alignment_x      (forces.alignment_x),
		.alignment_y      (forces.alignment_y),
		.separation_x     (forces.separation_x),
		.separation_y     (forces.separation_y),
		.cohesion_x       (forces.cohesion_x),
		.cohesion_y       (forces.cohesion_y),
		.alignment_count  (forces.alignment_count),
		.separation_count (forces.separation_count),
		.cohesion_count   (forces.cohesion_count)
	);

	localparam logic [CntW-1:0] CapChk = CntW'((MAX_NEIGHBORS < 511) ? MAX_NEIGHBORS : 511);

	// one item in flight: ready drops right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		nbr.valid && nbr.ready |=> !nbr.ready)
		else $error("item accepted while another is in flight");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		st.align_cnt <= CapChk && st.sep_cnt <= CapChk && st.coh_cnt <= CapChk)
		else $error("neighbor count above cap");

	// a fresh result always comes with cleared sums
	a_clear_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> st.align_cnt == '0 && st.sep_cnt == '0 && st.coh_cnt == '0)
		else $error("counts not cleared after result load");
endmodule
